>>> src/ssmd_pkg.sv
package ssmd_pkg;

  localparam int unsigned NUM_DIGITS = 4;
  localparam int unsigned DIGIT_IDX_W = $clog2(NUM_DIGITS);
  localparam int unsigned PATTERN_W = 8;
  localparam int unsigned BCD_W = 4;
  localparam int unsigned VALUE_W = 16;

  // Decimal point segment within a digit pattern.
  localparam logic [PATTERN_W-1:0] DP_BIT = 8'd8;
  localparam logic [VALUE_W-1:0] RADIX = 16'd10;

  // Reciprocal constants: q = (v * RECIP) >> SHIFT is exact for every 16-bit v.
  localparam int unsigned PROD_W = 33;
  localparam logic [16:0] RECIP_10 = 17'd52429;
  localparam int unsigned SHIFT_10 = 19;
  localparam logic [16:0] RECIP_100 = 17'd83887;
  localparam int unsigned SHIFT_100 = 23;
  localparam logic [16:0] RECIP_1000 = 17'd67109;
  localparam int unsigned SHIFT_1000 = 26;
  localparam logic [16:0] RECIP_10000 = 17'd107375;
  localparam int unsigned SHIFT_10000 = 30;

  // Quotient widths: v/10 <= 6553, v/100 <= 655, v/1000 <= 65, v/10000 <= 6.
  localparam int unsigned Q1_W = 13;
  localparam int unsigned Q2_W = 10;
  localparam int unsigned Q3_W = 7;
  localparam int unsigned Q4_W = 3;

  typedef logic [PATTERN_W-1:0] pattern_t;
  typedef logic [BCD_W-1:0] bcd_t;

  typedef enum logic [1:0] {
    CFG_DISPLAY_ENABLE = 2'd0,
    CFG_LEADING_ZEROS  = 2'd1,
    CFG_DP_DIGIT       = 2'd2
  } cfg_index_t;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_LOAD = 1'b1
  } op_t;

  function automatic pattern_t seg_lookup(input bcd_t digit);
    pattern_t pat;
    case (digit)
      4'd0:    pat = 8'd231;
      4'd1:    pat = 8'd36;
      4'd2:    pat = 8'd179;
      4'd3:    pat = 8'd182;
      4'd4:    pat = 8'd116;
      4'd5:    pat = 8'd214;
      4'd6:    pat = 8'd215;
      4'd7:    pat = 8'd164;
      4'd8:    pat = 8'd247;
      4'd9:    pat = 8'd246;
      default: pat = 8'd0;
    endcase
    return pat;
  endfunction

endpackage

>>> src/seven_segment_mux_display.sv
// Channel    Dir  Handshake            Payload
// s_*        in   s_tvalid / s_tready  tuser = op, tdata = load_value
// m_*        out  m_tvalid / m_tready  tdata = digit_enable, segment_drive
// cfg_*      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item per cycle is sustained while ticks can leave; a tick waits in the
// quotient register while the output register is full and not being emptied.
// An item passes the input register and the quotient register, then either
// updates the digit patterns (load) or lands in the output register (tick).
// A load produces no output transfer. Reset is synchronous and clears the
// pipeline, the scan index, the stored patterns and the configuration registers.
// When the output stalls, the pipeline keeps accepting until each stage holds an item.
module seven_segment_mux_display (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [15:0] load_value
  input  logic        s_tuser,   // [0] op: 0 scan tick, 1 load
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [3:0] digit_enable, [11:4] segment_drive, [15:12] zero
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data
);
  import ssmd_pkg::*;

  // Configuration registers. They are only read when a load finishes
  // encoding, so a write affects the next load.
  logic                 display_enable;
  logic                 leading_zeros_shown;
  logic [2:0]           dp_digit;

  // Stage A: input register.
  logic                 a_valid;
  logic                 a_op;
  logic [VALUE_W-1:0]   a_value;

  // Stage B: value plus its quotients by 10, 100, 1000 and 10000.
  logic                 b_valid;
  logic                 b_op;
  logic [VALUE_W-1:0]   b_value;
  logic [Q1_W-1:0]      b_q1;
  logic [Q2_W-1:0]      b_q2;
  logic [Q3_W-1:0]      b_q3;
  logic [Q4_W-1:0]      b_q4;

  // Display state.
  pattern_t             digit_patterns [NUM_DIGITS];
  logic [DIGIT_IDX_W-1:0] scan_index;
  logic [DIGIT_IDX_W-1:0] scan_index_next;

  // Output register.
  logic [NUM_DIGITS-1:0] digit_enable;
  pattern_t             segment_drive;

  // Handshake chain. A load in stage B always retires; a tick needs a free
  // output register, or one that is being emptied in this cycle.
  logic                 b_go;
  logic                 b_ready;
  logic                 a_ready;

  assign b_go     = b_valid && ((b_op == OP_LOAD) || !m_tvalid || m_tready);
  assign b_ready  = !b_valid || b_go;
  assign a_ready  = !a_valid || b_ready;
  assign s_tready = a_ready;
  assign cfg_ready = 1'b1;

  assign m_tdata = {4'd0, segment_drive, digit_enable};

  // Configuration port. Indexes past the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      display_enable      <= 1'b0;
      leading_zeros_shown <= 1'b0;
      dp_digit            <= 3'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DISPLAY_ENABLE: display_enable      <= cfg_data[0];
        CFG_LEADING_ZEROS:  leading_zeros_shown <= cfg_data[0];
        CFG_DP_DIGIT:       dp_digit            <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Stage A.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && s_tvalid) begin
      a_op    <= s_tuser;
      a_value <= s_tdata;
    end
  end

  // Quotients by constant reciprocal multiplication. Each one is taken
  // straight from the value, so the four products are independent.
  logic [PROD_W-1:0] prod_10;
  logic [PROD_W-1:0] prod_100;
  logic [PROD_W-1:0] prod_1000;
  logic [PROD_W-1:0] prod_10000;

  always_comb begin
    prod_10    = PROD_W'(a_value) * PROD_W'(RECIP_10);
    prod_100   = PROD_W'(a_value) * PROD_W'(RECIP_100);
    prod_1000  = PROD_W'(a_value) * PROD_W'(RECIP_1000);
    prod_10000 = PROD_W'(a_value) * PROD_W'(RECIP_10000);
  end

  // Stage B.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && a_valid) begin
      b_op    <= a_op;
      b_value <= a_value;
      b_q1    <= prod_10[SHIFT_10 +: Q1_W];
      b_q2    <= prod_100[SHIFT_100 +: Q2_W];
      b_q3    <= prod_1000[SHIFT_1000 +: Q3_W];
      b_q4    <= prod_10000[SHIFT_10000 +: Q4_W];
    end
  end

  // Digit extraction: each digit is a quotient minus ten times the next one.
  // The remainders are below ten, so the low four bits hold them exactly.
  logic [VALUE_W-1:0] rem0;
  logic [VALUE_W-1:0] rem1;
  logic [VALUE_W-1:0] rem2;
  logic [VALUE_W-1:0] rem3;
  bcd_t               dec [NUM_DIGITS];
  logic               leading [NUM_DIGITS];
  pattern_t           encoded [NUM_DIGITS];

  always_comb begin
    rem0 = b_value - VALUE_W'(b_q1) * RADIX;
    rem1 = VALUE_W'(b_q1) - VALUE_W'(b_q2) * RADIX;
    rem2 = VALUE_W'(b_q2) - VALUE_W'(b_q3) * RADIX;
    rem3 = VALUE_W'(b_q3) - VALUE_W'(b_q4) * RADIX;
    dec[0] = rem0[BCD_W-1:0];
    dec[1] = rem1[BCD_W-1:0];
    dec[2] = rem2[BCD_W-1:0];
    dec[3] = rem3[BCD_W-1:0];

    // A digit is a leading zero when it and every digit above it are zero.
    // The units digit never counts as leading.
    leading[3] = (dec[3] == '0);
    leading[2] = leading[3] && (dec[2] == '0);
    leading[1] = leading[2] && (dec[1] == '0);
    leading[0] = 1'b0;

    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (!display_enable) begin
        encoded[i] = '0;
      end else begin
        encoded[i] = (!leading_zeros_shown && leading[i]) ? '0 : seg_lookup(dec[i]);
        if (dp_digit == 3'(i)) begin
          encoded[i] = encoded[i] | DP_BIT;
        end
      end
    end
  end

  assign scan_index_next = scan_index + 1'b1;

  // Display state: a load rewrites all four patterns and restarts the scan.
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_index <= '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        digit_patterns[i] <= '0;
      end
    end else if (b_go) begin
      if (b_op == OP_LOAD) begin
        scan_index <= '0;
        for (int i = 0; i < NUM_DIGITS; i++) begin
          digit_patterns[i] <= encoded[i];
        end
      end else begin
        scan_index <= scan_index_next;
      end
    end
  end

  // Output register. A tick lights only the newly selected digit, which
  // turns off the previous one; segments are driven active low.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (b_go && (b_op == OP_TICK)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_go && (b_op == OP_TICK)) begin
      digit_enable  <= NUM_DIGITS'(1) << scan_index_next;
      segment_drive <= ~digit_patterns[scan_index_next];
    end
  end

  // A valid result always lights exactly one digit.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot(m_tdata[3:0]))
    else $error("digit enable is not one-hot");

  // A completed load restarts the scan at digit zero.
  assert property (@(posedge clk) disable iff (rst)
    (b_go && (b_op == OP_LOAD)) |=> (scan_index == '0))
    else $error("scan index not restarted by load");

  // A load with the display disabled leaves every pattern dark.
  assert property (@(posedge clk) disable iff (rst)
    (b_go && (b_op == OP_LOAD) && !display_enable) |=>
      ((digit_patterns[0] == '0) && (digit_patterns[1] == '0) &&
       (digit_patterns[2] == '0) && (digit_patterns[3] == '0)))
    else $error("disabled load stored a lit pattern");

  // A retired tick shows the digit the scan index now points at.
  assert property (@(posedge clk) disable iff (rst)
    (b_go && (b_op == OP_TICK)) |=>
      (m_tvalid && (m_tdata[3:0] == (NUM_DIGITS'(1) << scan_index))))
    else $error("output digit does not follow scan index");

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps

module tb;

  import ssmd_pkg::*;

  // The pipeline is three stages deep. A load leaves no output transfer behind,
  // so settle also waits out the pipeline before any register write.
  localparam int PIPE_SLACK = 8;
  // This index has no register behind it. Writes to it must change nothing.
  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int RANDOM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 125;

  // Scoreboard. It keeps a private copy of the display state and the
  // configuration. From the transfers accepted at the input it predicts every
  // scan result that the block must produce.
  class scan_checker;
    logic [7:0]  seg_of_digit [10];
    logic [7:0]  patterns [4];
    logic [1:0]  scan_pos;
    bit          show_digits;
    bit          show_zeros;
    logic [2:0]  point_digit;
    logic [15:0] expected_scans [$];
    int          errors;

    function new();
      seg_of_digit = '{8'd231, 8'd36, 8'd179, 8'd182, 8'd116,
                       8'd214, 8'd215, 8'd164, 8'd247, 8'd246};
      foreach (patterns[i]) patterns[i] = 8'd0;
      scan_pos    = 2'd0;
      show_digits = 1'b0;
      show_zeros  = 1'b0;
      point_digit = 3'd4;
      errors      = 0;
    endfunction

    function void write_register(logic [1:0] idx, logic [2:0] data);
      case (idx)
        CFG_DISPLAY_ENABLE: show_digits = data[0];
        CFG_LEADING_ZEROS:  show_zeros  = data[0];
        CFG_DP_DIGIT:       point_digit = data;
        default: ;
      endcase
    endfunction

    function void note_input(op_t op, logic [15:0] value);
      int unsigned dec [4];
      int unsigned rest;
      bit          leading;
      logic [7:0]  pat;
      if (op == OP_LOAD) begin
        rest = 32'(value);
        for (int i = 0; i < 4; i++) begin
          dec[i] = rest % 10;
          rest   = rest / 10;
        end
        leading = 1'b1;
        for (int i = 3; i >= 0; i--) begin
          // The units digit always ends the leading run.
          if (dec[i] != 0 || i == 0) leading = 1'b0;
          pat = (!show_zeros && leading) ? 8'd0 : seg_of_digit[dec[i]];
          // Codes 4 to 7 match no digit, so no point is lit for them.
          if (32'(point_digit) == i) pat = pat | DP_BIT;
          patterns[i] = show_digits ? pat : 8'd0;
        end
        scan_pos = 2'd0;
      end else begin
        scan_pos = scan_pos + 2'd1;
        expected_scans.push_back({4'd0, ~patterns[scan_pos], 4'b0001 << scan_pos});
      end
    endfunction

    function void check_result(logic [15:0] got);
      logic [15:0] exp;
      if (expected_scans.size() == 0) begin
        $display("%0t: unexpected output transfer, expected none, got %h", $time, got);
        errors++;
      end else begin
        exp = expected_scans.pop_front();
        if (got[3:0] !== exp[3:0]) begin
          $display("%0t: digit_enable expected %h, got %h", $time, exp[3:0], got[3:0]);
          errors++;
        end
        if (got[11:4] !== exp[11:4]) begin
          $display("%0t: segment_drive expected %h, got %h", $time, exp[11:4], got[11:4]);
          errors++;
        end
        if (got[15:12] !== exp[15:12]) begin
          $display("%0t: tdata padding expected %h, got %h", $time, exp[15:12], got[15:12]);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_scans.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = 16'd0;
  logic        s_tuser = OP_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [2:0]  cfg_data = 3'd0;

  // While this is set, neither side inserts gaps or stalls.
  bit          calm = 1'b0;
  scan_checker scan_check;

  seven_segment_mux_display u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Safety limit. A correct run needs only a small fraction of this time.
  initial begin
    #3_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // The output side. Runs of ready alternate with stall bursts of random length.
  // Some ready runs are long enough that the pipeline drains freely. While calm, ready stays high.
  initial begin
    int run;
    @(negedge rst);
    forever begin
      if (calm) begin
        @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        run = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        repeat (run) begin
          @(negedge clk);
          m_tready <= 1'b1;
        end
        run = $urandom_range(1, 8);
        repeat (run) begin
          @(negedge clk);
          m_tready <= 1'b0;
        end
      end
    end
  end

  // Every output transfer is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) scan_check.check_result(m_tdata);
  end

  // Offers one item at the falling edge, sometimes after a gap, and holds it
  // until the transfer takes place.
  task automatic send_item(op_t op, logic [15:0] value);
    int gap;
    if (!calm && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(0, 7);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    scan_check.note_input(op, value);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [2:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    scan_check.write_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Stops the input, waits for all outstanding scan results, then waits out
  // the pipeline in case a trailing load is still on its way in.
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (scan_check.pending() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  // Load values are spread over the digit counts. A share is above 9999, so
  // the top digit wraps.
  function automatic logic [15:0] pick_value();
    logic [15:0] v;
    case ($urandom_range(0, 6))
      0, 1: v = 16'($urandom_range(0, 65535));
      2:    v = 16'($urandom_range(0, 9));
      3:    v = 16'($urandom_range(10, 99));
      4:    v = 16'($urandom_range(100, 999));
      5:    v = 16'($urandom_range(1000, 9999));
      default: v = 16'(1000 * $urandom_range(0, 65));
    endcase
    return v;
  endfunction

  task automatic send_ticks(int count);
    repeat (count) send_item(OP_TICK, 16'($urandom_range(0, 65535)));
  endtask

  initial begin
    int sent;
    int burst;
    logic [2:0] dp_choice;
    scan_check = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part.
    // The first tick after reset shows digit 1 with all segments dark.
    send_ticks(1);
    settle();
    write_cfg(CFG_DISPLAY_ENABLE, 3'd1);
    write_cfg(CFG_LEADING_ZEROS, 3'd0);
    write_cfg(CFG_DP_DIGIT, 3'd4);
    // Zero blanks everything except the units digit. Four ticks wrap the scan.
    send_item(OP_LOAD, 16'd0);
    send_ticks(4);
    // The largest value. The scan restarts, so the first tick lights digit 1.
    send_item(OP_LOAD, 16'd65535);
    send_ticks(2);
    // The top digit of 10000 wraps to zero and is blanked.
    send_item(OP_LOAD, 16'd10000);
    send_ticks(1);
    settle();
    // With leading zeros shown, the point lands on a visible zero.
    write_cfg(CFG_LEADING_ZEROS, 3'd1);
    write_cfg(CFG_DP_DIGIT, 3'd3);
    send_item(OP_LOAD, 16'd5);
    send_ticks(3);
    settle();
    // The point on a blanked digit leaves only the point segment lit.
    write_cfg(CFG_LEADING_ZEROS, 3'd0);
    send_item(OP_LOAD, 16'd5);
    send_ticks(3);
    settle();
    // Point codes from 4 up light no point.
    write_cfg(CFG_DP_DIGIT, 3'd7);
    send_item(OP_LOAD, 16'd9999);
    send_ticks(3);
    settle();
    // A disabled display stores dark patterns, point included.
    write_cfg(CFG_DISPLAY_ENABLE, 3'd0);
    write_cfg(CFG_DP_DIGIT, 3'd0);
    send_item(OP_LOAD, 16'd1234);
    send_ticks(1);

    // Random part. Each phase gets a new configuration. Most items are a load
    // followed by a few ticks, and the rest are single items of either kind.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      calm = (phase >= RANDOM_PHASES - 2);
      case (phase)
        0:       dp_choice = 3'd0;
        2:       dp_choice = 3'd7;
        3:       dp_choice = 3'd4;
        5:       dp_choice = 3'd3;
        default: dp_choice = 3'($urandom_range(0, 7));
      endcase
      write_cfg(CFG_DISPLAY_ENABLE,
                (phase == 1) ? 3'd6 : 3'($urandom_range(0, 3) != 0 ? 7 : 0));
      write_cfg(CFG_LEADING_ZEROS, 3'($urandom_range(0, 7)));
      write_cfg(CFG_DP_DIGIT, dp_choice);
      if ($urandom_range(0, 2) == 0) write_cfg(CFG_UNUSED, 3'($urandom_range(0, 7)));
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 9) < 8) begin
          burst = $urandom_range(1, 8);
          send_item(OP_LOAD, pick_value());
          send_ticks(burst);
          sent += burst + 1;
        end else begin
          send_item($urandom_range(0, 1) ? OP_LOAD : OP_TICK, 16'($urandom_range(0, 65535)));
          sent++;
        end
      end
    end

    settle();
    if (scan_check.pending() != 0) begin
      $display("%0t: %0d expected scan results never arrived", $time, scan_check.pending());
    end
    if (scan_check.errors == 0 && scan_check.pending() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
